>>> hdl/kbh_pkg.sv
// key bigram histogram: shared types, constants and helper functions
// used by the sequencer, the top level and the channel interfaces
// no dependencies
package kbh_pkg;

  // table geometry: 30 rows of 31 columns, column 30 holds the single count
  localparam int NumRows    = 30;
  localparam int NumCols    = 31;
  localparam int TableDepth = NumRows * NumCols;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int ClassW     = 5;
  localparam int CodeW      = 16;
  localparam int ResultW    = 32;

  localparam logic [ClassW-1:0] SingleCol = 5'd30;
  localparam logic [ClassW-1:0] Untracked = 5'd30;
  localparam logic [ClassW-1:0] NoClass   = 5'd31;

  // character codes
  localparam logic [CodeW-1:0] CodeLowerA     = 16'd97;
  localparam logic [CodeW-1:0] CodeLowerZ     = 16'd122;
  localparam logic [CodeW-1:0] CodeSemicolon  = 16'd59;
  localparam logic [CodeW-1:0] CodeApostrophe = 16'd39;
  localparam logic [CodeW-1:0] CodeComma      = 16'd44;
  localparam logic [CodeW-1:0] CodePeriod     = 16'd46;

  // punctuation classes
  localparam logic [ClassW-1:0] ClsSemicolon  = 5'd26;
  localparam logic [ClassW-1:0] ClsApostrophe = 5'd27;
  localparam logic [ClassW-1:0] ClsComma      = 5'd28;
  localparam logic [ClassW-1:0] ClsPeriod     = 5'd29;

  // request commands
  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAIR_WR,
    ST_SNG_WR,
    ST_READ_DATA,
    ST_DONE
  } state_t;

  // memory port control from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] raddr;
  } ram_ctl_t;

  // one finished result
  typedef struct packed {
    logic [ResultW-1:0] count_value;
    logic [ClassW-1:0]  class_index;
    logic               pair_counted;
  } result_t;

  // map a character code to its class, untracked codes give Untracked
  function automatic logic [ClassW-1:0] classify(input logic [CodeW-1:0] code);
    logic [CodeW-1:0] diff;
    diff = code - CodeLowerA;
    priority if (code >= CodeLowerA && code <= CodeLowerZ) return diff[ClassW-1:0];
    else if (code == CodeSemicolon)  return ClsSemicolon;
    else if (code == CodeApostrophe) return ClsApostrophe;
    else if (code == CodeComma)      return ClsComma;
    else if (code == CodePeriod)     return ClsPeriod;
    else                             return Untracked;
  endfunction

  // row * 31 + col, as (row << 5) - row + col
  function automatic logic [AddrW-1:0] table_addr(input logic [ClassW-1:0] row,
                                                   input logic [ClassW-1:0] col);
    logic [AddrW-1:0] r;
    logic [AddrW-1:0] c;
    r = AddrW'(row);
    c = AddrW'(col);
    return (r << 5) - r + c;
  endfunction

endpackage

>>> hdl/kbh_in_if.sv
// key bigram histogram: request channel (valid/ready plus payload)
// depends on kbh_pkg
interface kbh_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [kbh_pkg::CodeW-1:0]  char_code;
  logic [kbh_pkg::ClassW-1:0] read_row;
  logic [kbh_pkg::ClassW-1:0] read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

>>> hdl/kbh_out_if.sv
// key bigram histogram: result channel (valid/ready plus payload)
// depends on kbh_pkg
interface kbh_out_if;
  logic                        valid;
  logic                        ready;
  logic [kbh_pkg::ResultW-1:0] count_value;
  logic [kbh_pkg::ClassW-1:0]  class_index;
  logic                        pair_counted;

  modport source (output valid, count_value, class_index, pair_counted, input ready);
  modport sink   (input valid, count_value, class_index, pair_counted, output ready);
endinterface

>>> hdl/kbh_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module kbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 930
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/kbh_seq.sv
// key bigram histogram sequencer: request intake, clearing pass and
// read-modify-write of the count memory; depends on kbh_pkg, kbh_in_if
module kbh_seq #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  kbh_in_if.sink                item,
  output kbh_pkg::ram_ctl_t     ram_ctl,
  output logic [COUNT_WIDTH-1:0] ram_wdata,
  input  logic [COUNT_WIDTH-1:0] ram_rdata,
  output logic                  res_valid,
  input  logic                  res_take,
  output kbh_pkg::result_t      res
);

  localparam int ExtW = (COUNT_WIDTH > kbh_pkg::ResultW) ? COUNT_WIDTH : kbh_pkg::ResultW;

  kbh_pkg::state_t               state;
  kbh_pkg::state_t               state_next;
  logic [kbh_pkg::ClassW-1:0]    prev_class;
  logic [kbh_pkg::AddrW-1:0]     pair_addr;
  logic [kbh_pkg::AddrW-1:0]     sng_addr;
  logic [kbh_pkg::AddrW-1:0]     clr_addr;

  logic                          accept;
  logic                          is_char;
  logic                          code_zero;
  logic                          tracked;
  logic                          has_prev;
  logic                          rd_ok;
  logic [kbh_pkg::ClassW-1:0]    in_cls;
  logic [kbh_pkg::AddrW-1:0]     in_pair_addr;
  logic [kbh_pkg::AddrW-1:0]     in_sng_addr;
  logic [kbh_pkg::AddrW-1:0]     in_rd_addr;
  logic [COUNT_WIDTH-1:0]        sat_inc;
  logic [ExtW-1:0]               rdata_ext;

  // decode of the incoming request
  assign accept       = item.valid && item.ready;
  assign is_char      = (item.command == kbh_pkg::CMD_CHAR);
  assign code_zero    = (item.char_code == '0);
  assign in_cls       = kbh_pkg::classify(item.char_code);
  assign tracked      = (in_cls != kbh_pkg::Untracked);
  assign has_prev     = (prev_class < kbh_pkg::ClassW'(kbh_pkg::NumRows));
  assign rd_ok        = (item.read_row < kbh_pkg::ClassW'(kbh_pkg::NumRows)) &&
                        (item.read_col < kbh_pkg::ClassW'(kbh_pkg::NumCols));
  assign in_pair_addr = kbh_pkg::table_addr(prev_class, in_cls);
  assign in_sng_addr  = kbh_pkg::table_addr(in_cls, kbh_pkg::SingleCol);
  assign in_rd_addr   = kbh_pkg::table_addr(item.read_row, item.read_col);

  // saturating increment of the word just read
  assign sat_inc   = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
  assign rdata_ext = ExtW'(ram_rdata);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kbh_pkg::ST_CLEAR: begin
        if (clr_addr == kbh_pkg::AddrW'(kbh_pkg::TableDepth - 1)) begin
          state_next = kbh_pkg::ST_IDLE;
        end
      end
      kbh_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (!is_char) begin
            state_next = rd_ok ? kbh_pkg::ST_READ_DATA : kbh_pkg::ST_DONE;
          end else if (code_zero || !tracked) begin
            state_next = kbh_pkg::ST_DONE;
          end else begin
            state_next = has_prev ? kbh_pkg::ST_PAIR_WR : kbh_pkg::ST_SNG_WR;
          end
        end
      end
      kbh_pkg::ST_PAIR_WR:   state_next = kbh_pkg::ST_SNG_WR;
      kbh_pkg::ST_SNG_WR:    state_next = kbh_pkg::ST_DONE;
      kbh_pkg::ST_READ_DATA: state_next = kbh_pkg::ST_DONE;
      kbh_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = kbh_pkg::ST_IDLE;
        end
      end
      default: state_next = kbh_pkg::ST_CLEAR;
    endcase
  end

  // outputs: memory control, handshake
  always_comb begin
    ram_ctl.we    = 1'b0;
    ram_ctl.waddr = sng_addr;
    ram_ctl.raddr = sng_addr;
    ram_wdata     = sat_inc;
    item.ready    = 1'b0;
    res_valid     = 1'b0;
    unique case (state)
      kbh_pkg::ST_CLEAR: begin
        ram_ctl.we    = 1'b1;
        ram_ctl.waddr = clr_addr;
        ram_wdata     = '0;
      end
      kbh_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        priority if (!is_char) begin
          ram_ctl.raddr = in_rd_addr;
        end else if (has_prev) begin
          ram_ctl.raddr = in_pair_addr;
        end else begin
          ram_ctl.raddr = in_sng_addr;
        end
      end
      kbh_pkg::ST_PAIR_WR: begin
        // pair and single entries differ in column, so the two overlap safely
        ram_ctl.we    = 1'b1;
        ram_ctl.waddr = pair_addr;
      end
      kbh_pkg::ST_SNG_WR: begin
        ram_ctl.we = 1'b1;
      end
      kbh_pkg::ST_READ_DATA: begin
      end
      kbh_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kbh_pkg::ST_CLEAR;
      prev_class <= kbh_pkg::NoClass;
      clr_addr   <= '0;
    end else begin
      state <= state_next;
      if (state == kbh_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + kbh_pkg::AddrW'(1);
      end
      // chain update on character requests other than code zero
      if (accept && is_char && !code_zero) begin
        prev_class <= tracked ? in_cls : kbh_pkg::NoClass;
      end
    end
  end

  // addresses and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      pair_addr            <= in_pair_addr;
      sng_addr             <= in_sng_addr;
      res.count_value      <= '0;
      res.class_index      <= (is_char && !code_zero) ? in_cls : kbh_pkg::Untracked;
      res.pair_counted     <= is_char && !code_zero && tracked && has_prev;
    end else if (state == kbh_pkg::ST_READ_DATA) begin
      res.count_value      <= rdata_ext[kbh_pkg::ResultW-1:0];
    end
  end

endmodule

>>> hdl/key_bigram_histogram_core.sv
// key bigram histogram top level: sequencer, count memory, result register
// request path: a tracked character with a previous class writes the pair, then
// the single count; one without writes the single count, a counter read in range
// fetches the data; no new request is taken until the result register takes this one
// reset: a clearing pass zeroes all 930 table entries, no requests taken meanwhile
module key_bigram_histogram_core #(
  parameter int COUNT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  kbh_in_if.sink    item,
  kbh_out_if.source result
);

  kbh_pkg::ram_ctl_t      ram_ctl;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   res_valid;
  logic                   res_take;
  kbh_pkg::result_t       res;

  // request sequencing
  kbh_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ram_ctl   (ram_ctl),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // count table
  kbh_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(kbh_pkg::TableDepth)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_wdata),
    .raddr (ram_ctl.raddr),
    .rdata (ram_rdata)
  );

  // result register, loads when empty or being drained
  assign res_take = res_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result.count_value  <= res.count_value;
      result.class_index  <= res.class_index;
      result.pair_counted <= res.pair_counted;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// key bigram histogram testbench: random and directed requests, a local histogram
// predictor and an in-order result scoreboard
// depends on kbh_pkg, kbh_in_if, kbh_out_if and key_bigram_histogram_core
module tb_top;

  localparam int CountW      = 32;
  localparam int WatchdogMax = 5000;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 200;

  typedef struct {
    kbh_pkg::cmd_t              command;
    logic [kbh_pkg::CodeW-1:0]  char_code;
    logic [kbh_pkg::ClassW-1:0] read_row;
    logic [kbh_pkg::ClassW-1:0] read_col;
  } key_req_t;

  logic clk;
  logic rst;
  logic req_taken = 1'b0;

  kbh_in_if  req_if ();
  kbh_out_if res_if ();

  key_bigram_histogram_core #(
    .COUNT_WIDTH(CountW)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (req_if.sink),
    .result(res_if.source)
  );

  key_req_t          pending_requests[$];
  kbh_pkg::result_t  predicted_results[$];

  // predictor state: pair and single counts plus the class chain
  logic [CountW-1:0]          tally[kbh_pkg::TableDepth];
  logic [kbh_pkg::ClassW-1:0] last_class;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int result_seq = 0;
  int idle_cycles = 0;

  // letters and marks that show up often, so that reads hit nonzero counts
  int hot_classes[8] = '{4, 19, 0, 14, 8, 13, 28, 29};

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] error: %s", $time, msg);
  endtask

  function automatic logic [kbh_pkg::ClassW-1:0] key_class(
      input logic [kbh_pkg::CodeW-1:0] code);
    if (code >= kbh_pkg::CodeLowerA && code <= kbh_pkg::CodeLowerZ) begin
      return kbh_pkg::ClassW'(code - kbh_pkg::CodeLowerA);
    end
    case (code)
      kbh_pkg::CodeSemicolon:  return kbh_pkg::ClsSemicolon;
      kbh_pkg::CodeApostrophe: return kbh_pkg::ClsApostrophe;
      kbh_pkg::CodeComma:      return kbh_pkg::ClsComma;
      kbh_pkg::CodePeriod:     return kbh_pkg::ClsPeriod;
      default:                 return kbh_pkg::Untracked;
    endcase
  endfunction

  function automatic void bump_tally(input int idx);
    if (tally[idx] != {CountW{1'b1}}) begin
      tally[idx] = tally[idx] + 1'b1;
    end
  endfunction

  // expected result of one request, advances the predictor state
  function automatic kbh_pkg::result_t histogram_step(input key_req_t req);
    kbh_pkg::result_t r;
    logic [kbh_pkg::ClassW-1:0] cls;
    r.count_value  = '0;
    r.class_index  = kbh_pkg::Untracked;
    r.pair_counted = 1'b0;
    if (req.command == kbh_pkg::CMD_READ) begin
      if (int'(req.read_row) < kbh_pkg::NumRows && int'(req.read_col) < kbh_pkg::NumCols) begin
        r.count_value = kbh_pkg::ResultW'(
            tally[int'(req.read_row) * kbh_pkg::NumCols + int'(req.read_col)]);
      end
    end else if (req.char_code != '0) begin
      cls = key_class(req.char_code);
      r.class_index = cls;
      if (cls == kbh_pkg::Untracked) begin
        last_class = kbh_pkg::NoClass;
      end else begin
        if (last_class != kbh_pkg::NoClass) begin
          bump_tally(int'(last_class) * kbh_pkg::NumCols + int'(cls));
          r.pair_counted = 1'b1;
        end
        bump_tally(int'(cls) * kbh_pkg::NumCols + int'(kbh_pkg::SingleCol));
        last_class = cls;
      end
    end
    return r;
  endfunction

  function automatic logic [kbh_pkg::CodeW-1:0] class_code(input int cls);
    if (cls < 26) begin
      return kbh_pkg::CodeLowerA + kbh_pkg::CodeW'(cls);
    end
    case (cls)
      26:      return kbh_pkg::CodeSemicolon;
      27:      return kbh_pkg::CodeApostrophe;
      28:      return kbh_pkg::CodeComma;
      default: return kbh_pkg::CodePeriod;
    endcase
  endfunction

  function automatic int pick_class();
    if ($urandom_range(1) == 1) begin
      return hot_classes[$urandom_range(7)];
    end
    return $urandom_range(kbh_pkg::NumRows - 1);
  endfunction

  // character request, the unused read fields carry noise
  task automatic queue_char(input logic [kbh_pkg::CodeW-1:0] code);
    key_req_t req;
    req.command   = kbh_pkg::CMD_CHAR;
    req.char_code = code;
    req.read_row  = kbh_pkg::ClassW'($urandom);
    req.read_col  = kbh_pkg::ClassW'($urandom);
    pending_requests.push_back(req);
  endtask

  // counter read request, the unused code field carries noise
  task automatic queue_read(input logic [kbh_pkg::ClassW-1:0] row,
                            input logic [kbh_pkg::ClassW-1:0] col);
    key_req_t req;
    req.command   = kbh_pkg::CMD_READ;
    req.char_code = kbh_pkg::CodeW'($urandom);
    req.read_row  = row;
    req.read_col  = col;
    pending_requests.push_back(req);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver and result back-pressure, both on the falling edge
  always @(negedge clk) begin
    key_req_t nxt;
    if (!rst && !(req_if.valid && !req_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        req_if.valid     <= 1'b1;
        req_if.command   <= nxt.command;
        req_if.char_code <= nxt.char_code;
        req_if.read_row  <= nxt.read_row;
        req_if.read_col  <= nxt.read_col;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check results against predictions, then predict accepted requests
  always @(posedge clk) begin
    kbh_pkg::result_t want;
    key_req_t         seen;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending", result_seq));
        end else begin
          want = predicted_results.pop_front();
          if (res_if.count_value !== want.count_value) begin
            report_mismatch($sformatf("result %0d count_value got %0h want %0h",
                                      result_seq, res_if.count_value, want.count_value));
          end
          if (res_if.class_index !== want.class_index) begin
            report_mismatch($sformatf("result %0d class_index got %0d want %0d",
                                      result_seq, res_if.class_index, want.class_index));
          end
          if (res_if.pair_counted !== want.pair_counted) begin
            report_mismatch($sformatf("result %0d pair_counted got %0b want %0b",
                                      result_seq, res_if.pair_counted, want.pair_counted));
          end
        end
        result_seq++;
      end
      if (req_if.valid && req_if.ready) begin
        seen.command   = kbh_pkg::cmd_t'(req_if.command);
        seen.char_code = req_if.char_code;
        seen.read_row  = req_if.read_row;
        seen.read_col  = req_if.read_col;
        predicted_results.push_back(histogram_step(seen));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WatchdogMax) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("[%0t] error: no handshake for %0d cycles", $time, WatchdogMax);
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus: reset, directed requests, then three random phases
  initial begin
    int counted;
    int roll;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.command   = kbh_pkg::CMD_CHAR;
    req_if.char_code = '0;
    req_if.read_row  = '0;
    req_if.read_col  = '0;
    res_if.ready     = 1'b0;
    foreach (tally[i]) tally[i] = '0;
    last_class = kbh_pkg::NoClass;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // reads of a freshly cleared table
        queue_read(5'd0, 5'd0);
        queue_read(5'd29, kbh_pkg::SingleCol);
        // first character has no predecessor, then every mark in a chain
        queue_char(kbh_pkg::CodeLowerA);
        queue_char(kbh_pkg::CodeLowerZ);
        queue_char(kbh_pkg::CodeSemicolon);
        queue_char(kbh_pkg::CodeApostrophe);
        queue_char(kbh_pkg::CodeComma);
        queue_char(kbh_pkg::CodePeriod);
        // code zero keeps the chain: period then a still pairs
        queue_char('0);
        queue_char(kbh_pkg::CodeLowerA);
        // untracked codes around the tracked ranges break the chain
        queue_char(kbh_pkg::CodeLowerA - 16'd1);
        queue_char(kbh_pkg::CodeLowerA + 16'd1);
        queue_char(kbh_pkg::CodeLowerZ + 16'd1);
        queue_char(kbh_pkg::CodeLowerA + 16'd2);
        queue_char(16'hFFFF);
        queue_char(kbh_pkg::CodeLowerA + 16'd3);
        queue_char(16'd32);
        // counters just touched, then reads outside the table
        queue_read(5'd0, 5'd25);
        queue_read(5'd25, kbh_pkg::ClsSemicolon);
        queue_read(kbh_pkg::ClsPeriod, 5'd0);
        queue_read(5'd0, kbh_pkg::SingleCol);
        queue_read(5'd30, 5'd0);
        queue_read(5'd31, 5'd31);
        queue_read(5'd0, 5'd31);
      end

      counted = 0;
      while (counted < PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 58) begin
          queue_char(class_code(pick_class()));
        end else if (roll < 64) begin
          queue_char('0);
        end else if (roll < 70) begin
          queue_char(16'd32);
        end else if (roll < 76) begin
          queue_char(kbh_pkg::CodeW'($urandom));
        end else if (roll < 92) begin
          queue_read(kbh_pkg::ClassW'(pick_class()),
                     ($urandom_range(3) == 0) ? kbh_pkg::SingleCol
                                              : kbh_pkg::ClassW'(pick_class()));
        end else begin
          queue_read(kbh_pkg::ClassW'($urandom), kbh_pkg::ClassW'($urandom));
        end
        if (roll < 58 || roll >= 64) begin
          counted++;
        end
      end

      // hold the sender until every result of this phase is back
      while (pending_requests.size() != 0 || req_if.valid || predicted_results.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/kbh_pkg.sv
hdl/kbh_in_if.sv
hdl/kbh_out_if.sv
hdl/kbh_ram.sv
hdl/kbh_seq.sv
hdl/key_bigram_histogram_core.sv
tb/sv/tb_top.sv
